// ----- hdl/btm_pkg.sv -----
// package for the breakpoint table matcher: sizes, request codes, beat structs
// and controller state type; no dependencies
package btm_pkg;

    localparam int ENTRIES   = 16;
    localparam int ADDR_BITS = 32;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    localparam logic [2:0] REQ_INSERT   = 3'd0;
    localparam logic [2:0] REQ_DEL_SLOT = 3'd1;
    localparam logic [2:0] REQ_DEL_ADDR = 3'd2;
    localparam logic [2:0] REQ_CHK_STOP = 3'd3;
    localparam logic [2:0] REQ_CHK_QUIET = 3'd4;
    localparam logic [2:0] REQ_MISC     = 3'd5;
    localparam logic [2:0] REQ_RSVD6    = 3'd6;
    localparam logic [2:0] REQ_RSVD7    = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        read_not_clear;
        logic [31:0] address;
        logic [3:0]  slot;
        logic [63:0] step_count;
        logic [2:0]  access_kind;
        logic [1:0]  address_kind;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [3:0]  hit_slot;
        logic        hit_pending;
        logic [31:0] entry_hits;
        logic [31:0] entry_address;
        logic [4:0]  entry_count;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, set search index (slot for slot removal, else zero)
        logic step_srch; // advance search index
        logic step_shft; // move next entry down one slot
        logic finish;    // apply update and build the result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_srch;  // request needs an address search
        logic srch_end;   // search index at end of table or match found
        logic need_shift; // removal found a slot to drop
        logic shft_end;   // shift reached the last valid entry
    } sts_t;

endpackage

// ----- hdl/breakpoint_table_matcher.sv -----
// breakpoint table matcher: one request per beat, one result beat per request
// a request is captured, then the table is scanned slot by slot where the
// request needs an address search and, on removal, later entries are shifted
// down one by one before the result beat is registered; the next request is
// taken in the cycle that the result beat is taken
// reset clears the entry count, last stop step and hit record; entries undefined
module breakpoint_table_matcher (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  btm_pkg::req_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output btm_pkg::rsp_t   out_data
);
    import btm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    btm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    btm_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_data),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (out_data)
    );

    // a result beat never reports more entries than the table holds
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.entry_count <= 5'(ENTRIES))
        else $error("entry count out of range");

    // a hit always leaves the record pending
    a_hit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.hit) |-> out_data.hit_pending)
        else $error("hit without pending record");

    // a held result stays stable until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");

endmodule

// ----- hdl/btm_ctrl.sv -----
// controller for the breakpoint table matcher: sequences search, shift and
// result phases; uses btm_pkg
module btm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  btm_pkg::sts_t   sts,
    output btm_pkg::cmd_t   cmd
);
    import btm_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (!sts.need_srch || sts.srch_end)
                begin
                    if (sts.need_shift)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.step_srch = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (sts.shft_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step_shft = 1'b1;
                end
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                in_ready = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load = 1'b1;
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/btm_dpath.sv -----
// datapath for the breakpoint table matcher: entry table, search index,
// shift logic and result register; uses btm_pkg
module btm_dpath (
    input  logic            clk,
    input  logic            rst_n,
    input  btm_pkg::req_t   req,
    input  btm_pkg::cmd_t   cmd,
    output btm_pkg::sts_t   sts,
    output btm_pkg::rsp_t   rsp
);
    import btm_pkg::*;

    logic [ADDR_BITS-1:0] ent_addr [ENTRIES];
    logic [31:0]          ent_hits [ENTRIES];
    logic [2:0]           ent_acc  [ENTRIES];
    logic [1:0]           ent_akd  [ENTRIES];
    logic                 ent_skip [ENTRIES];

    req_t                 req_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic                 found_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [63:0]          last_step_reg;
    logic                 rec_valid_reg;
    logic [3:0]           rec_slot_reg;
    rsp_t                 rsp_reg;

    logic [ADDR_BITS-1:0] key;
    logic                 is_srch;
    logic                 match;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     nxt_idx;
    logic [IDX_W-1:0]     cnt_idx;
    logic [IDX_W-1:0]     slot_idx;
    logic                 slot_ok;
    logic [CNT_W-1:0]     slot_ext;
    logic                 drop;
    logic                 ins_ok;
    logic                 chk_hit;
    logic [31:0]          hits_inc;
    rsp_t                 rsp_next;

    assign key      = ADDR_BITS'(req_reg.address);
    assign idx      = idx_reg[IDX_W-1:0];
    assign nxt_idx  = IDX_W'(idx_reg + CNT_W'(1));
    assign cnt_idx  = IDX_W'(cnt_reg);
    assign slot_idx = IDX_W'(req_reg.slot);
    assign slot_ext = CNT_W'(req_reg.slot);
    assign slot_ok  = (slot_ext < cnt_reg) && (slot_ext < CNT_W'(ENTRIES));
    assign is_srch  = (req_reg.req_type == REQ_INSERT && cnt_reg < CNT_W'(ENTRIES))
                   || req_reg.req_type == REQ_DEL_ADDR
                   || req_reg.req_type == REQ_CHK_STOP
                   || req_reg.req_type == REQ_CHK_QUIET;
    assign match    = (idx_reg < cnt_reg) && (ent_addr[idx] == key);
    assign drop     = (req_reg.req_type == REQ_DEL_SLOT && slot_ok)
                   || (req_reg.req_type == REQ_DEL_ADDR && found_reg);
    assign ins_ok   = (req_reg.req_type == REQ_INSERT) && (cnt_reg < CNT_W'(ENTRIES))
                   && !found_reg;
    assign chk_hit  = (req_reg.req_type == REQ_CHK_STOP || req_reg.req_type == REQ_CHK_QUIET)
                   && found_reg && (req_reg.step_count > last_step_reg);
    assign hits_inc = (ent_hits[idx] == 32'hFFFF_FFFF) ? ent_hits[idx]
                                                       : ent_hits[idx] + 32'd1;

    // status to the controller
    always_comb
    begin
        sts.need_srch  = is_srch && !found_reg;
        sts.srch_end   = found_reg || (idx_reg >= cnt_reg);
        sts.need_shift = drop;
        sts.shft_end   = (idx_reg + CNT_W'(1)) >= cnt_reg;
    end

    // result fields for the finishing request
    always_comb
    begin
        rsp_next = '0;
        case (req_reg.req_type)
            REQ_INSERT:
            begin
                if (cnt_reg >= CNT_W'(ENTRIES))
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            REQ_DEL_SLOT, REQ_DEL_ADDR:
            begin
                if (!drop)
                begin
                    rsp_next.status = ST_NOTFOUND;
                end
            end
            REQ_CHK_STOP, REQ_CHK_QUIET:
            begin
                if (chk_hit)
                begin
                    rsp_next.hit           = 1'b1;
                    rsp_next.entry_hits    = hits_inc;
                    rsp_next.entry_address = 32'(ent_addr[idx]);
                end
            end
            REQ_MISC:
            begin
                if (req_reg.read_not_clear)
                begin
                    if (slot_ok)
                    begin
                        rsp_next.entry_hits    = ent_hits[slot_idx];
                        rsp_next.entry_address = 32'(ent_addr[slot_idx]);
                    end
                    else
                    begin
                        rsp_next.status = ST_NOTFOUND;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // request capture, search index, count, hit record and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg       <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            last_step_reg <= '0;
            rec_valid_reg <= 1'b0;
            rec_slot_reg  <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                req_reg   <= req;
                found_reg <= 1'b0;
                idx_reg   <= (req.req_type == REQ_DEL_SLOT) ? CNT_W'(req.slot) : '0;
            end
            else if (cmd.step_srch)
            begin
                if (match)
                begin
                    found_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            else if (cmd.step_shft)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            else if (cmd.finish)
            begin
                rsp_reg <= rsp_next;
                if (ins_ok)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                else if (drop)
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                if (chk_hit)
                begin
                    rec_valid_reg <= 1'b1;
                    rec_slot_reg  <= 4'(idx_reg);
                    if (req_reg.req_type == REQ_CHK_STOP)
                    begin
                        last_step_reg <= req_reg.step_count;
                    end
                end
                else if (req_reg.req_type == REQ_MISC && !req_reg.read_not_clear)
                begin
                    rec_valid_reg <= 1'b0;
                end
            end
        end
    end

    // entry table writes: shift down, insert and hit update
    always_ff @(posedge clk)
    begin
        if (cmd.step_shft)
        begin
            ent_addr[idx] <= ent_addr[nxt_idx];
            ent_hits[idx] <= ent_hits[nxt_idx];
            ent_acc[idx]  <= ent_acc[nxt_idx];
            ent_akd[idx]  <= ent_akd[nxt_idx];
            ent_skip[idx] <= ent_skip[nxt_idx];
        end
        else if (cmd.finish)
        begin
            if (ins_ok)
            begin
                ent_addr[cnt_idx] <= key;
                ent_hits[cnt_idx] <= '0;
                ent_acc[cnt_idx]  <= req_reg.access_kind;
                ent_akd[cnt_idx]  <= req_reg.address_kind;
                ent_skip[cnt_idx] <= 1'b0;
            end
            if (chk_hit)
            begin
                ent_hits[idx] <= hits_inc;
                ent_skip[idx] <= 1'b1;
            end
        end
    end

    // hit slot, pending flag and count follow the updated record
    always_comb
    begin
        rsp = rsp_reg;
        rsp.hit_pending = rec_valid_reg;
        rsp.entry_count = 5'(cnt_reg);
        if (rsp_reg.hit)
        begin
            rsp.hit_slot = rec_slot_reg;
        end
        else
        begin
            rsp.hit_slot = rec_valid_reg ? rec_slot_reg : 4'd0;
        end
    end

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the breakpoint table matcher
// depends on btm_pkg and breakpoint_table_matcher
`timescale 1ns / 1ps

module testbench;
    import btm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2 * ENTRIES + 10;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    req_t  in_data;
    logic  out_valid;
    logic  out_ready;
    rsp_t  out_data;

    breakpoint_table_matcher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // predicted table state
    logic [31:0] tbl_addr [ENTRIES];
    logic [31:0] tbl_hits [ENTRIES];
    int          tbl_count;
    logic [63:0] stop_step;
    logic        rec_valid;
    logic [3:0]  rec_slot;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   error_count;
    int   idle_cycles;
    bit   stim_done;
    bit   hold_sender;
    int   gap_left;
    int   burst_left;
    int   stall_left;
    int   long_stall;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int find_bp(logic [31:0] a);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_addr[i] == a)
                return i;
        end
        return ENTRIES;
    endfunction

    function automatic void drop_bp(int s);
        for (int i = s; i + 1 < tbl_count; i++)
        begin
            tbl_addr[i] = tbl_addr[i + 1];
            tbl_hits[i] = tbl_hits[i + 1];
        end
        tbl_count--;
    endfunction

    // compute the response for one request and advance the table state
    function automatic rsp_t match_request(req_t r);
        rsp_t o;
        int   s;
        o = '0;
        o.status = ST_OK;
        case (r.req_type)
            REQ_INSERT:
            begin
                if (tbl_count >= ENTRIES)
                    o.status = ST_FULL;
                else if (find_bp(r.address) == ENTRIES)
                begin
                    tbl_addr[tbl_count] = r.address;
                    tbl_hits[tbl_count] = '0;
                    tbl_count++;
                end
            end
            REQ_DEL_SLOT:
            begin
                if (int'(r.slot) < tbl_count)
                    drop_bp(int'(r.slot));
                else
                    o.status = ST_NOTFOUND;
            end
            REQ_DEL_ADDR:
            begin
                s = find_bp(r.address);
                if (s < ENTRIES)
                    drop_bp(s);
                else
                    o.status = ST_NOTFOUND;
            end
            REQ_CHK_STOP, REQ_CHK_QUIET:
            begin
                s = find_bp(r.address);
                if (s < ENTRIES && r.step_count > stop_step)
                begin
                    if (tbl_hits[s] != 32'hFFFF_FFFF)
                        tbl_hits[s]++;
                    rec_valid = 1'b1;
                    rec_slot  = s[3:0];
                    if (r.req_type == REQ_CHK_STOP)
                        stop_step = r.step_count;
                    o.hit           = 1'b1;
                    o.hit_slot      = s[3:0];
                    o.entry_hits    = tbl_hits[s];
                    o.entry_address = tbl_addr[s];
                end
            end
            REQ_MISC:
            begin
                if (!r.read_not_clear)
                    rec_valid = 1'b0;
                else if (int'(r.slot) < tbl_count)
                begin
                    o.entry_hits    = tbl_hits[r.slot];
                    o.entry_address = tbl_addr[r.slot];
                end
                else
                    o.status = ST_NOTFOUND;
            end
            default:
            begin
            end
        endcase
        if (!o.hit && rec_valid)
            o.hit_slot = rec_slot;
        o.hit_pending = rec_valid;
        o.entry_count = tbl_count[4:0];
        return o;
    endfunction

    function automatic req_t random_request(logic [31:0] pool[8]);
        req_t r;
        r.req_type       = 3'($urandom_range(0, 7));
        r.read_not_clear = 1'($urandom);
        r.address        = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)]
                                                       : $urandom;
        r.slot           = 4'($urandom);
        r.step_count     = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                       : 64'($urandom_range(0, 4000));
        r.access_kind    = 3'($urandom);
        r.address_kind   = 2'($urandom);
        return r;
    endfunction

    function automatic req_t make_req(logic [2:0] kind, logic [31:0] a,
                                      logic [3:0] sl, logic [63:0] st, logic rd);
        req_t r;
        r.req_type       = kind;
        r.read_not_clear = rd;
        r.address        = a;
        r.slot           = sl;
        r.step_count     = st;
        r.access_kind    = 3'($urandom);
        r.address_kind   = 2'($urandom);
        return r;
    endfunction

    // stimulus
    initial
    begin
        logic [31:0] pool[8];
        stim_done   = 1'b0;
        hold_sender = 1'b0;
        for (int i = 0; i < 8; i++)
            pool[i] = $urandom;
        pool[0] = 32'h0;
        pool[1] = 32'hFFFF_FFFF;
        // directed: fill, full, duplicate, checks, saturation-free, removals, misc
        for (int i = 0; i < ENTRIES; i++)
            pending_reqs.push_back(make_req(REQ_INSERT, (i == 0) ? 32'h0 :
                                   (i == 1) ? 32'hFFFF_FFFF : 32'h100 + 32'(i), 4'd0,
                                   64'd0, 1'b0));
        pending_reqs.push_back(make_req(REQ_INSERT, 32'h1234, 4'd0, 64'd0, 1'b0));
        pending_reqs.push_back(make_req(REQ_CHK_STOP, 32'hFFFF_FFFF, 4'd0, 64'd0, 1'b0));
        pending_reqs.push_back(make_req(REQ_CHK_STOP, 32'hFFFF_FFFF, 4'd0,
                                        64'hFFFF_FFFF_FFFF_FFFE, 1'b0));
        pending_reqs.push_back(make_req(REQ_CHK_QUIET, 32'h105, 4'd0,
                                        64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        pending_reqs.push_back(make_req(REQ_MISC, 32'h0, 4'd15, 64'd0, 1'b1));
        pending_reqs.push_back(make_req(REQ_DEL_SLOT, 32'h0, 4'd1, 64'd0, 1'b0));
        pending_reqs.push_back(make_req(REQ_INSERT, 32'h105, 4'd0, 64'd0, 1'b0));
        pending_reqs.push_back(make_req(REQ_DEL_ADDR, 32'h105, 4'd0, 64'd0, 1'b0));
        pending_reqs.push_back(make_req(REQ_DEL_ADDR, 32'hDEAD, 4'd0, 64'd0, 1'b0));
        pending_reqs.push_back(make_req(REQ_DEL_SLOT, 32'h0, 4'd15, 64'd0, 1'b0));
        pending_reqs.push_back(make_req(REQ_MISC, 32'h0, 4'd15, 64'd0, 1'b1));
        pending_reqs.push_back(make_req(REQ_MISC, 32'h0, 4'd0, 64'd0, 1'b0));
        pending_reqs.push_back(make_req(REQ_RSVD6, 32'h0, 4'd0, 64'd0, 1'b0));
        pending_reqs.push_back(make_req(REQ_RSVD7, 32'hFFFF_FFFF, 4'd15, 64'd0, 1'b1));
        // random part with a drained pause in the middle
        for (int i = 0; i < 900; i++)
        begin
            if (i == 450)
            begin
                wait (pending_reqs.size() == 0);
                hold_sender = 1'b1;
                wait (expected_rsps.size() == 0 && !in_valid);
                repeat (20) @(posedge clk);
                hold_sender = 1'b0;
            end
            pending_reqs.push_back(random_request(pool));
        end
        stim_done = 1'b1;
    end

    // reset
    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            gap_left   <= 0;
            burst_left <= 0;
            tbl_count  = 0;
            stop_step  = '0;
            rec_valid  = 1'b0;
            rec_slot   = '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_rsps.push_back(match_request(in_data));
            if (in_valid && !in_ready)
            begin
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() > 0 && !hold_sender)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_reqs.pop_front();
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern with one long hold-off while the sender offers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            long_stall <= 0;
        end
        else if (long_stall == 0 && out_valid && in_valid)
        begin
            long_stall <= 1;
            stall_left <= 300;
            out_ready  <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                stall_left <= $urandom_range(1, 10);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, out_data);
                error_count++;
            end
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                if (out_data !== exp_rsp)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_rsp, out_data);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // end of run
    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        wait (stim_done && pending_reqs.size() == 0);
        @(posedge clk);
        wait (!in_valid && expected_rsps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/btm_pkg.sv
hdl/btm_ctrl.sv
hdl/btm_dpath.sv
hdl/breakpoint_table_matcher.sv
tb/testbench.sv
